@@ src/dobd_pkg.sv @@
// Shared types and calendar helpers for the date offset block.
// Depends on nothing; imported by the controller, datapath and top level.
package dobd_pkg;

	// Calendar constants
	localparam logic [11:0] YEAR_MIN = 12'd1970;
	localparam logic [11:0] YEAR_MAX = 12'd2099;
	localparam logic [3:0]  MON_JAN  = 4'd1;
	localparam logic [3:0]  MON_FEB  = 4'd2;
	localparam logic [3:0]  MON_DEC  = 4'd12;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_NORM,
		ST_WALK,
		ST_DONE
	} dobd_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;
		logic norm;
		logic step;
		logic finish;
	} dobd_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic walk_more;
	} dobd_stat_t;

	// Leap rule over the reachable years (about 1790..2280): multiples of four,
	// less the century years that are not multiples of 400.
	function automatic logic is_leap(input logic [11:0] y);
		logic cent;
		cent = (y == 12'd1800) || (y == 12'd1900) || (y == 12'd2100) || (y == 12'd2200);
		return (y[1:0] == 2'b00) && !cent;
	endfunction

	// Length of month m in year y; a month code outside 1..12 reads as January
	function automatic logic [4:0] month_len(input logic [11:0] y, input logic [3:0] m);
		logic [4:0] len;
		case (m) inside
			MON_FEB:                  len = is_leap(y) ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
			default:                  len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

@@ src/date_offset_by_days.sv @@
// Top level of the Gregorian date offset block: controller plus datapath.
// Depends on dobd_pkg, dobd_ctrl and dobd_dpath.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------------
//  item in  | start & !busy         | mode, start_day, start_month, start_year, day_count
//  result   | done (one cycle)      | result_day, result_month, result_year, start_defaulted
//
// An item is accepted, normalised, walked month by month and then shown by the done strobe;
// the month walk crosses one boundary per cycle, up to about 2160 boundaries for 65535 days.
// busy is high from the cycle after acceptance until done has been shown. Reset clears
// the controller and the datapath registers. The receiver cannot stall: done lasts one
// cycle.
module date_offset_by_days (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        mode,
	input  logic [4:0]  start_day,
	input  logic [3:0]  start_month,
	input  logic [11:0] start_year,
	input  logic [15:0] day_count,
	output logic        done,
	output logic [4:0]  result_day,
	output logic [3:0]  result_month,
	output logic [11:0] result_year,
	output logic        start_defaulted
);
	import dobd_pkg::*;

	dobd_cmd_t  cmd;
	dobd_stat_t stat;

	// Sequencer
	dobd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Date arithmetic
	dobd_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.mode            (mode),
		.start_day       (start_day),
		.start_month     (start_month),
		.start_year      (start_year),
		.day_count       (day_count),
		.stat            (stat),
		.result_day      (result_day),
		.result_month    (result_month),
		.result_year     (result_year),
		.start_defaulted (start_defaulted)
	);

endmodule

@@ src/dobd_ctrl.sv @@
// Sequencing state machine for the date offset block.
// Depends on dobd_pkg; drives the datapath through dobd_cmd_t.
module dobd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  dobd_pkg::dobd_stat_t stat,
	output dobd_pkg::dobd_cmd_t  cmd,
	output logic                busy,
	output logic                done
);
	import dobd_pkg::*;

	dobd_state_t state_q;
	dobd_state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_nxt = ST_NORM;
			end
			ST_NORM: state_nxt = ST_WALK;
			ST_WALK: begin
				if (!stat.walk_more) state_nxt = ST_DONE;
			end
			ST_DONE: state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_NORM: cmd.norm = 1'b1;
			ST_WALK: begin
				cmd.step   = stat.walk_more;
				cmd.finish = !stat.walk_more;
			end
			ST_DONE: done = 1'b1;
			default: busy = 1'b1;
		endcase
	end

`ifndef ASSERT_OFF
	// A result only follows the end of the month walk
	a_done_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.finish))
		else $error("done without a finishing walk");

	// One strobe per item
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// An accepted item keeps the block busy on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not make the block busy");
`endif

endmodule

@@ src/dobd_dpath.sv @@
// Date registers and month-walk arithmetic for the date offset block.
// Depends on dobd_pkg; commanded by dobd_ctrl.
module dobd_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  dobd_pkg::dobd_cmd_t  cmd,
	input  logic                mode,
	input  logic [4:0]          start_day,
	input  logic [3:0]          start_month,
	input  logic [11:0]         start_year,
	input  logic [15:0]         day_count,
	output dobd_pkg::dobd_stat_t stat,
	output logic [4:0]          result_day,
	output logic [3:0]          result_month,
	output logic [11:0]         result_year,
	output logic                start_defaulted
);
	import dobd_pkg::*;

	logic        mode_q;
	logic        dflt_q;
	logic [4:0]  d_q;
	logic [3:0]  m_q;
	logic [11:0] y_q;
	logic [15:0] n_q;

	logic        in_ok;
	logic [4:0]  len_cur;
	logic [4:0]  room;
	logic [3:0]  m_next, m_prev;
	logic [11:0] y_next, y_prev;
	logic [4:0]  len_prev;

	// Start date check
	assign in_ok = (start_day != 5'd0) && (start_month >= MON_JAN) && (start_month <= MON_DEC)
		&& (start_year >= YEAR_MIN) && (start_year <= YEAR_MAX);

	// Month neighbours and lengths
	assign len_cur  = month_len(y_q, m_q);
	assign room     = len_cur - d_q;
	assign m_next   = (m_q == MON_DEC) ? MON_JAN : 4'(m_q + 4'd1);
	assign y_next   = (m_q == MON_DEC) ? 12'(y_q + 12'd1) : y_q;
	assign m_prev   = (m_q == MON_JAN) ? MON_DEC : 4'(m_q - 4'd1);
	assign y_prev   = (m_q == MON_JAN) ? 12'(y_q - 12'd1) : y_q;
	assign len_prev = month_len(y_prev, m_prev);

	// Another month to cross?
	assign stat.walk_more = mode_q ? (n_q >= {11'd0, d_q}) : (n_q > {11'd0, room});

	// Working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			n_q    <= '0;
			dflt_q <= 1'b0;
			d_q    <= 5'd1;
			m_q    <= MON_JAN;
			y_q    <= YEAR_MIN;
		end else if (cmd.load) begin
			mode_q <= mode;
			n_q    <= day_count;
			dflt_q <= !in_ok;
			d_q    <= in_ok ? start_day   : 5'd1;
			m_q    <= in_ok ? start_month : MON_JAN;
			y_q    <= in_ok ? start_year  : YEAR_MIN;
		end else if (cmd.norm) begin
			// carry an over-long start day into the next month
			if (d_q > len_cur) begin
				d_q <= d_q - len_cur;
				m_q <= m_next;
				y_q <= y_next;
			end
		end else if (cmd.step) begin
			if (mode_q) begin
				n_q <= n_q - {11'd0, d_q};
				m_q <= m_prev;
				y_q <= y_prev;
				d_q <= len_prev;
			end else begin
				n_q <= n_q - ({11'd0, room} + 16'd1);
				m_q <= m_next;
				y_q <= y_next;
				d_q <= 5'd1;
			end
		end
	end

	// Result registers; the remaining count fits in five bits here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_day      <= '0;
			result_month    <= '0;
			result_year     <= '0;
			start_defaulted <= 1'b0;
		end else if (cmd.finish) begin
			result_day      <= mode_q ? (d_q - n_q[4:0]) : (d_q + n_q[4:0]);
			result_month    <= m_q;
			result_year     <= y_q;
			start_defaulted <= dflt_q;
		end
	end

`ifndef ASSERT_OFF
	// Finished day is nonzero
	a_day_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.finish) |-> (result_day != 5'd0))
		else $error("result day is zero");

	// Finished month is in range
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.finish) |-> ((result_month >= MON_JAN) && (result_month <= MON_DEC)))
		else $error("result month out of range");

	// A walk step always consumes days
	a_step_consumes: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> (n_q < $past(n_q)))
		else $error("walk step left the count unchanged");
`endif

endmodule
